[src/lrl_pkg.sv]
// Package for the LRU recency list: command and status codes, sequencer states
// and default sizes. It depends on nothing else.
`default_nettype none

package lrl_pkg;

   localparam int unsigned LRL_ENTRIES   = 16;
   localparam int unsigned LRL_KEY_WIDTH = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_MOVE   = 2'd2,
      CMD_FIND   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_SLOT  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_CHK_RD,
      S_CHK_EVAL,
      S_UNL_RD,
      S_UNL_WR,
      S_LINK_A,
      S_LINK_B,
      S_FIND_RD,
      S_FIND_CHK,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

[src/lrl_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
// It is used for the keys, the links and the in-use flags of the list.
`default_nettype none

module lrl_ram #(
   parameter int unsigned WIDTH      = 4,
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned ADDR_WIDTH = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/lru_recency_list.sv]
// LRU recency list: a circular doubly linked ring over ENTRIES slots in RAM.
// One request at a time, under a sequencer that reads a slot in one state and checks it
// in the next. Insert links the lowest free slot in at the head; find walks the ring
// from the head. Delete unlinks a slot; move to head relinks it at the head, unless it is the head.
// After reset a clearing pass zeroes the in-use flags; no request is taken meanwhile.
// Depends on lrl_pkg and lrl_ram.
`default_nettype none

module lru_recency_list
   import lrl_pkg::*;
#(
   parameter int unsigned ENTRIES   = LRL_ENTRIES,
   parameter int unsigned KEY_WIDTH = LRL_KEY_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // cmd[1:0], key[33:2], slot[37:34], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // status[1:0], result_slot[5:2], head_slot[9:6],
                                         // tail_slot[13:10], entry_total[18:14], zero pad
);

   localparam int unsigned SW = $clog2(ENTRIES);
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam int unsigned KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

   state_type  state_ff, state_in;
   cmd_type    cmd_ff, cmd_in;
   status_type status_ff, status_in;
   logic [KW-1:0] key_ff, key_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW-1:0] rslot_ff, rslot_in;
   logic [SW-1:0] head_ff, head_in;
   logic [SW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] step_ff, step_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [18:0]   rsp_data_ff, rsp_data_in;

   logic          key_we, next_we, prev_we, used_we;
   logic [SW-1:0] key_wa, next_wa, prev_wa, used_wa;
   logic [KW-1:0] key_wd, key_rd;
   logic [SW-1:0] next_wd, prev_wd, next_rd, prev_rd;
   logic [0:0]    used_wd, used_rd;

   logic [SW+3:0] slot_wide;
   logic [SW-1:0] req_slot_idx;
   logic          req_slot_ok;
   logic [SW-1:0] link_h, link_t;
   logic [SW+3:0] rslot_wide, head_wide, tail_wide;
   logic [CW+4:0] count_wide;

   assign slot_wide    = {{SW{1'b0}}, req_tdata[37:34]};
   assign req_slot_idx = slot_wide[SW-1:0];
   assign req_slot_ok  = slot_wide < (SW + 4)'(ENTRIES);

   assign link_h = (count_ff == '0) ? idx_ff : head_ff;
   assign link_t = (count_ff == '0) ? idx_ff : tail_ff;

   assign rslot_wide = {4'b0, rslot_ff};
   assign head_wide  = {4'b0, head_ff};
   assign tail_wide  = {4'b0, tail_ff};
   assign count_wide = {5'b0, count_ff};

   lrl_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
      .rd_addr(idx_ff), .rd_data(key_rd)
   );

   lrl_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(idx_ff), .rd_data(next_rd)
   );

   lrl_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_prev_ram (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(idx_ff), .rd_data(prev_rd)
   );

   lrl_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_used_ram (
      .clock(clock), .wr_en(used_we), .wr_addr(used_wa), .wr_data(used_wd),
      .rd_addr(idx_ff), .rd_data(used_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      status_ff   <= status_in;
      key_ff      <= key_in;
      rslot_ff    <= rslot_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      status_in    = status_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      rslot_in     = rslot_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      key_we  = 1'b0;
      next_we = 1'b0;
      prev_we = 1'b0;
      used_we = 1'b0;
      key_wa  = idx_ff;
      next_wa = idx_ff;
      prev_wa = idx_ff;
      used_wa = idx_ff;
      key_wd  = key_ff;
      next_wd = link_h;
      prev_wd = link_t;
      used_wd = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            used_we = 1'b1;
            used_wd = 1'b0;
            idx_in  = idx_ff + SW'(1);
            if (idx_ff == SW'(ENTRIES - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in    = cmd_type'(req_tdata[1:0]);
               key_in    = req_tdata[KW+1:2];
               status_in = ST_OK;
               rslot_in  = '0;
               step_in   = '0;
               unique case (cmd_type'(req_tdata[1:0]))
                  CMD_INSERT: begin
                     idx_in = '0;
                     if (count_ff == CW'(ENTRIES)) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  CMD_DELETE, CMD_MOVE: begin
                     rslot_in = req_slot_idx;
                     idx_in   = req_slot_idx;
                     if (!req_slot_ok) begin
                        status_in = ST_BAD_SLOT;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_CHK_RD;
                     end
                  end
                  CMD_FIND: begin
                     idx_in = head_ff;
                     if (count_ff == '0) begin
                        status_in = ST_NOT_FOUND;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_FIND_RD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (!used_rd[0]) begin
               rslot_in = idx_ff;
               state_in = S_LINK_A;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_CHK_RD: state_in = S_CHK_EVAL;
         S_CHK_EVAL: begin
            if (!used_rd[0]) begin
               status_in = ST_BAD_SLOT;
               state_in  = S_DONE;
            end else if (cmd_ff == CMD_MOVE && idx_ff == head_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_UNL_RD;
            end
         end
         S_UNL_RD: state_in = S_UNL_WR;
         S_UNL_WR: begin
            if (count_ff <= CW'(1)) begin
               head_in = '0;
            end else begin
               next_we = 1'b1;
               next_wa = prev_rd;
               next_wd = next_rd;
               prev_we = 1'b1;
               prev_wa = next_rd;
               prev_wd = prev_rd;
               if (head_ff == idx_ff) begin
                  head_in = next_rd;
               end
               if (tail_ff == idx_ff) begin
                  tail_in = prev_rd;
               end
            end
            count_in = count_ff - CW'(1);
            if (cmd_ff == CMD_DELETE) begin
               used_we  = 1'b1;
               used_wd  = 1'b0;
               state_in = S_DONE;
            end else begin
               state_in = S_LINK_A;
            end
         end
         S_LINK_A: begin
            next_we = 1'b1;
            next_wd = link_h;
            prev_we = 1'b1;
            prev_wd = link_t;
            if (cmd_ff == CMD_INSERT) begin
               key_we  = 1'b1;
               key_wd  = key_ff;
               used_we = 1'b1;
               used_wd = 1'b1;
            end
            state_in = S_LINK_B;
         end
         S_LINK_B: begin
            next_we  = 1'b1;
            next_wa  = link_t;
            next_wd  = idx_ff;
            prev_we  = 1'b1;
            prev_wa  = link_h;
            prev_wd  = idx_ff;
            head_in  = idx_ff;
            if (count_ff == '0) begin
               tail_in = idx_ff;
            end
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end
         S_FIND_RD: state_in = S_FIND_CHK;
         S_FIND_CHK: begin
            if (key_rd == key_ff) begin
               rslot_in = idx_ff;
               state_in = S_DONE;
            end else if (step_ff + CW'(1) == count_ff) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               idx_in   = next_rd;
               step_in  = step_ff + CW'(1);
               state_in = S_FIND_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in[1:0]   = status_ff;
               rsp_data_in[5:2]   = rslot_wide[3:0];
               rsp_data_in[9:6]   = (count_ff == '0) ? 4'b0 : head_wide[3:0];
               rsp_data_in[13:10] = (count_ff == '0) ? 4'b0 : tail_wide[3:0];
               rsp_data_in[18:14] = count_wide[4:0];
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

endmodule

`default_nettype wire
